FILE: design/lbe_pkg.sv
`default_nettype none

package lbe_pkg;

	localparam int BYTE_W   = 8;
	localparam int ALPHABET = 256;
	localparam int OUT_W    = 16;
	localparam int KEY_W    = 32;
	localparam int STEP_W   = 2;
	// stream tag kept in every slot, a stale tag reads as an empty slot
	localparam int EPOCH_W  = 8;
	localparam logic [KEY_W-1:0] HASH_MULT = 32'd2654435761;

	// steps of the slot index reduction
	localparam logic [STEP_W-1:0] RED_QUO = 2'd0;
	localparam logic [STEP_W-1:0] RED_SUB = 2'd1;
	localparam logic [STEP_W-1:0] RED_FIX = 2'd2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_REDUCE,
		ST_READ,
		ST_CHECK,
		ST_EMIT_MISS,
		ST_EMIT_FINAL
	} state_t;

endpackage

`default_nettype wire

FILE: design/lbe_ram.sv
`default_nettype none

module lbe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: design/lzw_byte_encoder_unit.sv
`default_nettype none

// channel | signals                                      | direction
// --------+----------------------------------------------+----------
// input   | in_valid, in_ready, data_byte, end_of_stream | into block
// output  | out_valid, out_ready, out_code, final_code   | from block
//
// a byte that opens a stream only becomes the current match; a later byte goes through these steps:
// the accept, one multiply, then a ram read and a compare for each slot probed.
// a miss adds a step that loads its code, and the last byte of a stream a further step for the final code.
// when HASH_SLOTS is not a power of two the slot index is reduced on the same multiplier.
// after reset and after every 256th stream a clearing pass writes every slot to empty the table.
// a code load waits while the output register still holds an untaken transaction.
module lzw_byte_encoder_unit
	import lbe_pkg::*;
#(
	parameter int CODE_BITS  = 16,
	parameter int HASH_SLOTS = 131072
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [BYTE_W-1:0] data_byte,
	input  wire logic              end_of_stream,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic      [OUT_W-1:0]  out_code,
	output logic                   final_code
);

	localparam int ADDR_W  = $clog2(HASH_SLOTS);
	localparam bit IS_POW2 = (HASH_SLOTS == (1 << ADDR_W));
	localparam logic [ADDR_W:0] SLOTS_EXT = (ADDR_W+1)'(HASH_SLOTS);
	localparam logic [KEY_W-1:0] SLOTS_KEY = KEY_W'(HASH_SLOTS);
	localparam logic [KEY_W-1:0] RECIP     = KEY_W'((64'd1 << KEY_W) / HASH_SLOTS);

	typedef struct packed {
		logic                 valid;
		logic [EPOCH_W-1:0]   epoch;
		logic [CODE_BITS-1:0] prefix;
		logic [BYTE_W-1:0]    sym;
		logic [CODE_BITS-1:0] code;
	} slot_t;

	localparam int SLOT_W = $bits(slot_t);

	state_t state_q, state_d;

	logic [BYTE_W-1:0]    byte_q;
	logic                 last_q;
	logic [CODE_BITS-1:0] match_code_q;
	logic [CODE_BITS:0]   next_free_q;
	logic                 open_q;
	logic [EPOCH_W-1:0]   epoch_q;
	logic [KEY_W-1:0]     prod_q;
	logic [KEY_W-1:0]     quo_q;
	logic [ADDR_W:0]      rem_q;
	logic [STEP_W-1:0]    step_q;
	logic [ADDR_W-1:0]    idx_q;
	logic [ADDR_W:0]      probe_cnt_q;
	logic                 has_free_q;
	logic [ADDR_W-1:0]    clr_idx_q;
	logic                 out_valid_q;
	logic [OUT_W-1:0]     out_code_q;
	logic                 out_final_q;

	logic                 in_acc;
	logic                 slot_free;
	logic                 out_load;
	logic                 ram_we, ram_re;
	logic [ADDR_W-1:0]    ram_waddr;
	slot_t                ram_wdata;
	logic [SLOT_W-1:0]    ram_rdata;
	slot_t                rd_slot;
	logic                 slot_live, slot_hit, probes_done;
	logic [ADDR_W:0]      idx_inc;
	logic [ADDR_W-1:0]    idx_wrap;
	logic [ADDR_W-1:0]    rem_fix;
	logic [KEY_W-1:0]     hash_key;
	logic [KEY_W-1:0]     mul_a, mul_b;
	logic [2*KEY_W-1:0]   mul_p;
	logic                 do_insert;

	assign in_ready   = (state_q == ST_IDLE);
	assign in_acc     = in_valid && in_ready;
	assign slot_free  = !out_valid_q || out_ready;
	assign out_load   = slot_free && ((state_q == ST_EMIT_MISS) || (state_q == ST_EMIT_FINAL));
	assign out_valid  = out_valid_q;
	assign out_code   = out_code_q;
	assign final_code = out_final_q;

	assign rd_slot     = slot_t'(ram_rdata);
	assign slot_live   = rd_slot.valid && (rd_slot.epoch == epoch_q);
	assign slot_hit    = (rd_slot.prefix == match_code_q) && (rd_slot.sym == byte_q);
	assign probes_done = ((probe_cnt_q + 1'b1) == SLOTS_EXT);
	assign idx_inc     = {1'b0, idx_q} + 1'b1;
	assign idx_wrap    = (idx_inc == SLOTS_EXT) ? '0 : idx_inc[ADDR_W-1:0];

	// remainder by reciprocal: the quotient estimate is low by at most one,
	// so a single compare and subtract finishes it
	assign rem_fix = (rem_q >= SLOTS_EXT) ? ADDR_W'(rem_q - SLOTS_EXT) : rem_q[ADDR_W-1:0];

	assign hash_key  = KEY_W'({match_code_q, byte_q});
	assign do_insert = has_free_q && !next_free_q[CODE_BITS];

	// one multiplier shared by the hash and the index reduction
	always_comb begin
		mul_a = hash_key;
		mul_b = HASH_MULT;
		if (state_q == ST_REDUCE) begin
			if (step_q == RED_QUO) begin
				mul_a = prod_q;
				mul_b = RECIP;
			end else begin
				mul_a = quo_q;
				mul_b = SLOTS_KEY;
			end
		end
	end

	assign mul_p = (2*KEY_W)'(mul_a) * (2*KEY_W)'(mul_b);

	lbe_ram #(
		.WIDTH(SLOT_W),
		.DEPTH(HASH_SLOTS)
	) u_dict (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(idx_q),
		.rdata(ram_rdata)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if ({1'b0, clr_idx_q} == SLOTS_EXT - 1'b1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_acc) begin
					if (!open_q) begin
						state_d = end_of_stream ? ST_EMIT_FINAL : ST_IDLE;
					end else begin
						state_d = ST_HASH;
					end
				end
			end
			ST_HASH: state_d = IS_POW2 ? ST_READ : ST_REDUCE;
			ST_REDUCE: begin
				if (step_q == RED_FIX) begin
					state_d = ST_READ;
				end
			end
			ST_READ: state_d = ST_CHECK;
			ST_CHECK: begin
				if (!slot_live) begin
					state_d = ST_EMIT_MISS;
				end else if (slot_hit) begin
					state_d = last_q ? ST_EMIT_FINAL : ST_IDLE;
				end else if (probes_done) begin
					state_d = ST_EMIT_MISS;
				end else begin
					state_d = ST_READ;
				end
			end
			ST_EMIT_MISS: begin
				if (slot_free) begin
					state_d = last_q ? ST_EMIT_FINAL : ST_IDLE;
				end
			end
			ST_EMIT_FINAL: begin
				if (slot_free) begin
					state_d = (epoch_q == '1) ? ST_CLEAR : ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = '0;
		ram_re    = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_idx_q;
			end
			ST_READ: ram_re = 1'b1;
			ST_EMIT_MISS: begin
				ram_we           = slot_free && do_insert;
				ram_wdata.valid  = 1'b1;
				ram_wdata.epoch  = epoch_q;
				ram_wdata.prefix = match_code_q;
				ram_wdata.sym    = byte_q;
				ram_wdata.code   = next_free_q[CODE_BITS-1:0];
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			match_code_q <= '0;
			next_free_q  <= (CODE_BITS+1)'(ALPHABET);
			open_q       <= 1'b0;
			epoch_q      <= '0;
			clr_idx_q    <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= (state_d == ST_IDLE) ? '0 : clr_idx_q + 1'b1;
				end
				ST_IDLE: begin
					if (in_acc && !open_q) begin
						match_code_q <= CODE_BITS'(data_byte);
						open_q       <= 1'b1;
					end
				end
				ST_CHECK: begin
					if (slot_live && slot_hit) begin
						match_code_q <= rd_slot.code;
					end
				end
				ST_EMIT_MISS: begin
					if (slot_free) begin
						match_code_q <= CODE_BITS'(byte_q);
						if (do_insert) begin
							next_free_q <= next_free_q + 1'b1;
						end
					end
				end
				ST_EMIT_FINAL: begin
					if (slot_free) begin
						match_code_q <= '0;
						open_q       <= 1'b0;
						next_free_q  <= (CODE_BITS+1)'(ALPHABET);
						epoch_q      <= epoch_q + 1'b1;
					end
				end
				default: begin
					open_q <= open_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					byte_q <= data_byte;
					last_q <= end_of_stream;
				end
			end
			ST_HASH: begin
				prod_q      <= mul_p[KEY_W-1:0];
				step_q      <= RED_QUO;
				probe_cnt_q <= '0;
				if (IS_POW2) begin
					idx_q <= mul_p[ADDR_W-1:0];
				end
			end
			ST_REDUCE: begin
				step_q <= step_q + 1'b1;
				case (step_q)
					RED_QUO: quo_q <= mul_p[2*KEY_W-1:KEY_W];
					RED_SUB: rem_q <= (ADDR_W+1)'(prod_q - mul_p[KEY_W-1:0]);
					default: idx_q <= rem_fix;
				endcase
			end
			ST_CHECK: begin
				if (!slot_live) begin
					has_free_q <= 1'b1;
				end else if (!slot_hit) begin
					if (probes_done) begin
						has_free_q <= 1'b0;
					end else begin
						idx_q       <= idx_wrap;
						probe_cnt_q <= probe_cnt_q + 1'b1;
					end
				end
			end
			ST_EMIT_MISS: begin
				if (slot_free) begin
					out_code_q  <= OUT_W'(match_code_q);
					out_final_q <= 1'b0;
				end
			end
			ST_EMIT_FINAL: begin
				if (slot_free) begin
					out_code_q  <= OUT_W'(match_code_q);
					out_final_q <= 1'b1;
				end
			end
			default: begin
				rem_q <= rem_q;
			end
		endcase
	end

endmodule

`default_nettype wire
